FILE: hdl/twhec_pkg.sv
package twhec_pkg;

  localparam int unsigned BUCKET_COUNT_DEF = 4096;
  localparam int unsigned WAYS = 3;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned TAG_LSB = 48;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // transaction kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_PROBE = 1'b1;

  // register select, taken from paddr[2]
  localparam logic REG_EXACT_BOUND = 1'b0;
  localparam logic REG_NULL_MOVE = 1'b1;

  localparam logic [1:0] EXACT_BOUND_RST = 2'd3;
  localparam logic [15:0] NULL_MOVE_RST = 16'd0;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [15:0] score;
    logic [15:0] static_score;
    logic [7:0] depth;
    logic [1:0] bound;
    logic pv;
    logic [15:0] move;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic kind;
    logic [KEY_W-1:0] hash_key;
    logic [15:0] score;
    logic [15:0] static_score;
    logic [7:0] search_depth;
    logic [1:0] bound_type;
    logic pv_flag;
    logic [15:0] move_code;
  } item_t;

  typedef struct packed {
    logic found;
    logic [15:0] found_score;
    logic [15:0] found_static_score;
    logic [7:0] found_depth;
    logic [1:0] found_bound;
    logic found_pv;
    logic [15:0] found_move;
  } result_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic clear;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic is_probe;
    logic out_busy;
  } sts_t;

endpackage

FILE: hdl/twhec_req_if.sv
interface twhec_req_if;
  logic valid;
  logic ready;
  logic kind;
  logic [63:0] hash_key;
  logic signed [15:0] score;
  logic signed [15:0] static_score;
  logic [7:0] search_depth;
  logic [1:0] bound_type;
  logic pv_flag;
  logic [15:0] move_code;

  modport source (
    output valid, kind, hash_key, score, static_score, search_depth, bound_type,
           pv_flag, move_code,
    input ready
  );

  modport sink (
    input valid, kind, hash_key, score, static_score, search_depth, bound_type,
          pv_flag, move_code,
    output ready
  );
endinterface

FILE: hdl/twhec_rsp_if.sv
interface twhec_rsp_if;
  logic valid;
  logic ready;
  logic found;
  logic signed [15:0] found_score;
  logic signed [15:0] found_static_score;
  logic [7:0] found_depth;
  logic [1:0] found_bound;
  logic found_pv;
  logic [15:0] found_move;

  modport source (
    output valid, found, found_score, found_static_score, found_depth, found_bound,
           found_pv, found_move,
    input ready
  );

  modport sink (
    input valid, found, found_score, found_static_score, found_depth, found_bound,
          found_pv, found_move,
    output ready
  );
endinterface

FILE: hdl/three_way_hash_entry_cache_core.sv
// Three-way set-associative position cache. Each transaction on req_i is a
// store (kind 0) or a probe (kind 1); a probe yields one transaction on
// rsp_o, a store yields none. The bucket is picked by the low log2(BUCKET_COUNT)
// key bits and entries are tagged by key bits 63:48, tag zero meaning empty.
// Every transaction goes through accept, registered bucket read and
// update or result, one transaction at a time, plus any wait for rsp_o to
// drain. After reset the bucket memory is swept to zero, one bucket per cycle,
// so req_i.ready stays low until the sweep is done; the APB registers
// (exact bound code at 0x0, null move code at 0x4) can be written meanwhile.
module three_way_hash_entry_cache_core #(
  parameter int unsigned BUCKET_COUNT = twhec_pkg::BUCKET_COUNT_DEF,
  localparam int unsigned IDX_W = $clog2(BUCKET_COUNT)
) (
  input  logic clk_i,
  input  logic rst_ni,
  twhec_req_if.sink req_i,
  twhec_rsp_if.source rsp_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [twhec_pkg::ADDR_W-1:0] paddr,
  input  logic [twhec_pkg::DATA_W-1:0] pwdata,
  output logic [twhec_pkg::DATA_W-1:0] prdata,
  output logic pready
);

  logic [1:0] exact_bound_q;
  logic [15:0] null_move_q;
  logic reg_wr;
  logic in_ready;
  twhec_pkg::item_t item;
  twhec_pkg::cmd_t cmd;
  twhec_pkg::sts_t sts;
  logic [IDX_W-1:0] clr_idx;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exact_bound_q <= twhec_pkg::EXACT_BOUND_RST;
      null_move_q <= twhec_pkg::NULL_MOVE_RST;
    end else if (reg_wr) begin
      unique case (paddr[2])
        twhec_pkg::REG_EXACT_BOUND: exact_bound_q <= pwdata[1:0];
        twhec_pkg::REG_NULL_MOVE:   null_move_q <= pwdata[15:0];
        default:                    exact_bound_q <= exact_bound_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      twhec_pkg::REG_EXACT_BOUND: prdata = {30'd0, exact_bound_q};
      twhec_pkg::REG_NULL_MOVE:   prdata = {16'd0, null_move_q};
      default:                    prdata = '0;
    endcase
  end

  assign item.kind = req_i.kind;
  assign item.hash_key = req_i.hash_key;
  assign item.score = req_i.score;
  assign item.static_score = req_i.static_score;
  assign item.search_depth = req_i.search_depth;
  assign item.bound_type = req_i.bound_type;
  assign item.pv_flag = req_i.pv_flag;
  assign item.move_code = req_i.move_code;
  assign req_i.ready = in_ready;

  twhec_ctrl #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i(req_i.valid),
    .in_ready_o(in_ready),
    .sts_i(sts),
    .cmd_o(cmd),
    .clr_idx_o(clr_idx)
  );

  twhec_datapath #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .item_i(item),
    .cmd_i(cmd),
    .clr_idx_i(clr_idx),
    .exact_bound_i(exact_bound_q),
    .null_move_i(null_move_q),
    .sts_o(sts),
    .rsp_o(rsp_o)
  );

endmodule

FILE: hdl/twhec_ctrl.sv
module twhec_ctrl #(
  parameter int unsigned BUCKET_COUNT = twhec_pkg::BUCKET_COUNT_DEF,
  localparam int unsigned IDX_W = $clog2(BUCKET_COUNT)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  twhec_pkg::sts_t sts_i,
  output twhec_pkg::cmd_t cmd_o,
  output logic [IDX_W-1:0] clr_idx_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic [IDX_W-1:0] clr_cnt_q;
  logic clr_last;

  assign clr_last = (clr_cnt_q == IDX_W'(BUCKET_COUNT - 1));
  assign clr_idx_o = clr_cnt_q;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_IDLE:  cmd_o.load = in_valid_i;
      ST_READ:  cmd_o.rd = 1'b1;
      ST_EXEC:  cmd_o.exec = !sts_i.is_probe || !sts_i.out_busy;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_READ;
        end
        ST_READ: state_q <= ST_EXEC;
        ST_EXEC: begin
          // a probe waits here until the result register can take it
          if (!sts_i.is_probe || !sts_i.out_busy) state_q <= ST_IDLE;
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

endmodule

FILE: hdl/twhec_datapath.sv
module twhec_datapath #(
  parameter int unsigned BUCKET_COUNT = twhec_pkg::BUCKET_COUNT_DEF,
  localparam int unsigned IDX_W = $clog2(BUCKET_COUNT)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  twhec_pkg::item_t item_i,
  input  twhec_pkg::cmd_t cmd_i,
  input  logic [IDX_W-1:0] clr_idx_i,
  input  logic [1:0] exact_bound_i,
  input  logic [15:0] null_move_i,
  output twhec_pkg::sts_t sts_o,
  twhec_rsp_if.source rsp_o
);

  twhec_pkg::item_t item_q;
  twhec_pkg::row_t mem_q [BUCKET_COUNT];
  twhec_pkg::row_t rdata_q;
  twhec_pkg::row_t new_row;
  twhec_pkg::entry_t cur;
  twhec_pkg::entry_t new_entry;
  twhec_pkg::result_t res;
  twhec_pkg::result_t out_q;
  logic out_valid_q;

  logic [twhec_pkg::TAG_W-1:0] tag;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] wr_addr;
  logic [1:0] sel;
  logic [9:0] new_pri3;
  logic [9:0] old_pri2;
  logic upgrade;
  logic replace;
  logic wr_en;
  logic is_probe;

  assign tag = item_q.hash_key[twhec_pkg::TAG_LSB +: twhec_pkg::TAG_W];
  assign idx = item_q.hash_key[IDX_W-1:0];
  assign is_probe = (item_q.kind == twhec_pkg::KIND_PROBE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
  end

  // slot choice: slot 0 if empty or matching, else first match, else shallowest
  always_comb begin
    sel = 2'd0;
    cur = rdata_q[0];
    if (rdata_q[0].tag != '0 && rdata_q[0].tag != tag) begin
      if (rdata_q[1].tag == tag) begin
        sel = 2'd1;
        cur = rdata_q[1];
      end else begin
        if (rdata_q[1].depth < cur.depth) begin
          sel = 2'd1;
          cur = rdata_q[1];
        end
        if (rdata_q[2].tag == tag || rdata_q[2].depth < cur.depth) begin
          sel = 2'd2;
          cur = rdata_q[2];
        end
      end
    end
  end

  // depth + 3 - bound never goes negative
  assign new_pri3 = 10'd3 * (10'(item_q.search_depth) + 10'd3 - 10'(item_q.bound_type));
  assign old_pri2 = 10'd2 * (10'(cur.depth) + 10'd3 - 10'(cur.bound));
  assign upgrade = (item_q.bound_type == exact_bound_i) && (cur.bound != exact_bound_i);
  assign replace = (cur.tag != tag) || upgrade || (new_pri3 >= old_pri2);

  always_comb begin
    new_entry.tag = tag;
    new_entry.score = item_q.score;
    new_entry.static_score = item_q.static_score;
    new_entry.depth = item_q.search_depth;
    new_entry.bound = item_q.bound_type;
    new_entry.pv = item_q.pv_flag;
    new_entry.move = item_q.move_code;
    if (item_q.move_code == null_move_i && cur.tag == tag) new_entry.move = cur.move;
    new_row = rdata_q;
    unique case (sel)
      2'd0:    new_row[0] = new_entry;
      2'd1:    new_row[1] = new_entry;
      2'd2:    new_row[2] = new_entry;
      default: new_row = rdata_q;
    endcase
  end

  assign wr_en = cmd_i.clear || (cmd_i.exec && !is_probe && replace);
  assign wr_addr = cmd_i.clear ? clr_idx_i : idx;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= cmd_i.clear ? '0 : new_row;
    if (cmd_i.rd) rdata_q <= mem_q[idx];
  end

  // probe returns the first matching way, all zero on a miss
  always_comb begin
    res = '0;
    priority if (rdata_q[0].tag == tag) begin
      res = {1'b1, rdata_q[0].score, rdata_q[0].static_score, rdata_q[0].depth,
             rdata_q[0].bound, rdata_q[0].pv, rdata_q[0].move};
    end else if (rdata_q[1].tag == tag) begin
      res = {1'b1, rdata_q[1].score, rdata_q[1].static_score, rdata_q[1].depth,
             rdata_q[1].bound, rdata_q[1].pv, rdata_q[1].move};
    end else if (rdata_q[2].tag == tag) begin
      res = {1'b1, rdata_q[2].score, rdata_q[2].static_score, rdata_q[2].depth,
             rdata_q[2].bound, rdata_q[2].pv, rdata_q[2].move};
    end else begin
      res = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec && is_probe) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && is_probe) out_q <= res;
  end

  assign sts_o.is_probe = is_probe;
  assign sts_o.out_busy = out_valid_q && !rsp_o.ready;

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.found = out_q.found;
  assign rsp_o.found_score = out_q.found_score;
  assign rsp_o.found_static_score = out_q.found_static_score;
  assign rsp_o.found_depth = out_q.found_depth;
  assign rsp_o.found_bound = out_q.found_bound;
  assign rsp_o.found_pv = out_q.found_pv;
  assign rsp_o.found_move = out_q.found_move;

endmodule
